>>> rtl/core/fxa_pkg.sv
// fxa_pkg: shared types and constants for the q24.8 fixed-point alu
// no dependencies; imported by every module under rtl/core
package fxa_pkg;

  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_DIV  = 4'd3,
    FN_MIN  = 4'd4,
    FN_MAX  = 4'd5,
    FN_INC  = 4'd6,
    FN_DEC  = 4'd7,
    FN_ITOF = 4'd8,
    FN_FTOI = 4'd9
  } func_t;

  localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;
  localparam int          REM_W   = 33;

  // request payload that rides along the divider stages
  typedef struct packed {
    logic [3:0]  func;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] simple;
    logic        simple_ovf;
    logic [63:0] prod;
    logic        neg;
    logic        dbz;
  } fxa_side_t;

endpackage

>>> rtl/core/fxa_front.sv
// fxa_front: first pipeline stage, simple ops, multiplier, divider operand prep
// depends on fxa_pkg
module fxa_front #(
  parameter int FRAC_BITS = 8,
  localparam int NW = 33 + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  v_i,
  input  logic [3:0]            func_i,
  input  logic signed [31:0]    a_i,
  input  logic signed [31:0]    b_i,
  output logic                  v_o,
  output fxa_pkg::fxa_side_t    side_o,
  output logic [NW-1:0]         num_o,
  output logic [fxa_pkg::REM_W-1:0] den_o
);
  import fxa_pkg::*;

  function automatic logic [32:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) begin
      return {1'b1, (s[32] ? RAW_MIN : RAW_MAX)};
    end
    return {1'b0, s[31:0]};
  endfunction

  logic [32:0]              a33, b33;
  logic [32:0]              add_s, sub_s, inc_s, dec_s;
  logic [31+FRAC_BITS:0]    itof_w;
  logic [FRAC_BITS:0]       itof_top;
  logic                     itof_ovf;
  logic [32:0]              itof_s;
  logic [31:0]              ftoi_v;
  logic [32:0]              simple_s;
  logic signed [63:0]       prod_c;
  logic [31:0]              ma, mb;
  logic                     v_r;
  fxa_side_t                side_r, side_nxt;
  logic [NW-1:0]            num_r, num_nxt;
  logic [REM_W-1:0]         den_r, den_nxt;

  always_comb begin
    a33    = {a_i[31], a_i};
    b33    = {b_i[31], b_i};
    add_s  = sat33(a33 + b33);
    sub_s  = sat33(a33 - b33);
    inc_s  = sat33(a33 + 33'd1);
    dec_s  = sat33(a33 - 33'd1);
    itof_w = {{FRAC_BITS{a_i[31]}}, a_i} << FRAC_BITS;
    itof_top = itof_w[31+FRAC_BITS:31];
    itof_ovf = !((&itof_top) || !(|itof_top));
    itof_s = itof_ovf ? {1'b1, (a_i[31] ? RAW_MIN : RAW_MAX)} : {1'b0, itof_w[31:0]};
    ftoi_v = 32'(a_i >>> FRAC_BITS);
    unique case (func_t'(func_i))
      FN_ADD:  simple_s = add_s;
      FN_SUB:  simple_s = sub_s;
      FN_MIN:  simple_s = {1'b0, ((a_i < b_i) ? a_i : b_i)};
      FN_MAX:  simple_s = {1'b0, ((a_i > b_i) ? a_i : b_i)};
      FN_INC:  simple_s = inc_s;
      FN_DEC:  simple_s = dec_s;
      FN_ITOF: simple_s = itof_s;
      FN_FTOI: simple_s = {1'b0, ftoi_v};
      default: simple_s = 33'd0;
    endcase
    prod_c = a_i * b_i;
    ma = a_i[31] ? (~a_i + 32'd1) : a_i;
    mb = b_i[31] ? (~b_i + 32'd1) : b_i;

    side_nxt.func       = func_i;
    side_nxt.gt         = a_i > b_i;
    side_nxt.lt         = a_i < b_i;
    side_nxt.eq         = a_i == b_i;
    side_nxt.simple     = simple_s[31:0];
    side_nxt.simple_ovf = simple_s[32];
    side_nxt.prod       = prod_c;
    side_nxt.neg        = a_i[31] ^ b_i[31];
    side_nxt.dbz        = (func_i == FN_DIV) && (b_i == 32'sd0);
    // rounding numerator 2|a|*2^f + |b| over denominator 2|b|
    num_nxt = {ma, {(FRAC_BITS+1){1'b0}}} + NW'(mb);
    den_nxt = {mb, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  assign v_o    = v_r;
  assign side_o = side_r;
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

>>> rtl/core/fxa_div_stage.sv
// fxa_div_stage: one restoring division step with its pipeline register
// depends on fxa_pkg
module fxa_div_stage #(
  parameter int NW = 41
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      v_i,
  input  fxa_pkg::fxa_side_t        side_i,
  input  logic [fxa_pkg::REM_W-1:0] rem_i,
  input  logic [NW-1:0]             quo_i,
  input  logic [fxa_pkg::REM_W-1:0] den_i,
  output logic                      v_o,
  output fxa_pkg::fxa_side_t        side_o,
  output logic [fxa_pkg::REM_W-1:0] rem_o,
  output logic [NW-1:0]             quo_o,
  output logic [fxa_pkg::REM_W-1:0] den_o
);
  import fxa_pkg::*;

  logic [REM_W:0]   t, diff;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;
  logic [NW-1:0]    quo_nxt;
  logic             v_r;
  fxa_side_t        side_r;
  logic [REM_W-1:0] rem_r, den_r;
  logic [NW-1:0]    quo_r;

  always_comb begin
    t       = {rem_i, quo_i[NW-1]};
    diff    = t - {1'b0, den_i};
    ge      = t >= {1'b0, den_i};
    rem_nxt = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
    quo_nxt = {quo_i[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_i;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
    end
  end

  assign v_o    = v_r;
  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;

endmodule

>>> rtl/core/fxa_post.sv
// fxa_post: rounding of the product, saturation and result select, two stages
// depends on fxa_pkg; the second stage is the output register
module fxa_post #(
  parameter int FRAC_BITS = 8,
  localparam int NW = 33 + FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               v_i,
  input  fxa_pkg::fxa_side_t side_i,
  input  logic [NW-1:0]      quo_i,
  output logic               v_o,
  output logic [31:0]        result_o,
  output logic               gt_o,
  output logic               lt_o,
  output logic               eq_o,
  output logic               ovf_o,
  output logic               dbz_o
);
  import fxa_pkg::*;

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  // stage a: magnitude and sign of mul or div
  logic [63:0] mm, mag_nxt, mag_r;
  logic        neg_nxt, neg_r, va_r;
  fxa_side_t   sa_r;

  always_comb begin
    mm = side_i.prod[63] ? (HALF - side_i.prod) : (side_i.prod + HALF);
    if (side_i.func == FN_MUL) begin
      mag_nxt = mm >> FRAC_BITS;
      neg_nxt = side_i.prod[63];
    end else begin
      mag_nxt = 64'(quo_i);
      neg_nxt = side_i.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      sa_r  <= side_i;
    end
  end

  // stage b: clamp and pick
  logic        sat;
  logic [31:0] sres, res_nxt;
  logic        ovf_nxt, dbz_nxt;
  logic        vb_r;
  logic [31:0] res_r;
  logic        gt_r, lt_r, eq_r, ovf_r, dbz_r;

  always_comb begin
    sat  = neg_r ? (mag_r > 64'h8000_0000) : (mag_r > 64'h7fff_ffff);
    sres = sat ? (neg_r ? RAW_MIN : RAW_MAX)
               : (neg_r ? (~mag_r[31:0] + 32'd1) : mag_r[31:0]);
    dbz_nxt = 1'b0;
    if (sa_r.func == FN_MUL) begin
      res_nxt = sres;
      ovf_nxt = sat;
    end else if (sa_r.func == FN_DIV) begin
      res_nxt = sa_r.dbz ? 32'd0 : sres;
      ovf_nxt = sa_r.dbz ? 1'b0 : sat;
      dbz_nxt = sa_r.dbz;
    end else begin
      res_nxt = sa_r.simple;
      ovf_nxt = sa_r.simple_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
      dbz_r <= dbz_nxt;
      gt_r  <= sa_r.gt;
      lt_r  <= sa_r.lt;
      eq_r  <= sa_r.eq;
    end
  end

  assign v_o      = vb_r;
  assign result_o = res_r;
  assign gt_o     = gt_r;
  assign lt_o     = lt_r;
  assign eq_o     = eq_r;
  assign ovf_o    = ovf_r;
  assign dbz_o    = dbz_r;

endmodule

>>> rtl/core/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: top level of the pipelined q24.8 fixed-point alu
// depends on fxa_pkg, fxa_front, fxa_div_stage, fxa_post
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_func, in_operand_a, in_operand_b
//   out_     output     out_valid/out_stall  out_result and five flag bits
//
// one request enters per cycle while in_stall is low; the pipe is the front stage,
// the restoring divider with one quotient bit per stage over 33+FRAC_BITS
// stages, and two rounding/saturation stages
// every op takes the same path so results leave in request order
// synchronous active-low reset clears the valid bits only
// a stall at the output freezes the whole pipe; nothing is lost or repeated
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_a_greater,
  output logic               out_a_less,
  output logic               out_a_equal,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);
  import fxa_pkg::*;

  // numerator width of the rounding divide
  localparam int NW = 33 + FRAC_BITS;

  // the pipe moves whenever the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // divider chain taps, index 0 is the front stage output
  logic             dv   [0:NW];
  fxa_side_t        dside[0:NW];
  logic [REM_W-1:0] drem [0:NW];
  logic [NW-1:0]    dquo [0:NW];
  logic [REM_W-1:0] dden [0:NW];

  assign drem[0] = '0;

  fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (in_valid),
    .func_i (in_func),
    .a_i    (in_operand_a),
    .b_i    (in_operand_b),
    .v_o    (dv[0]),
    .side_o (dside[0]),
    .num_o  (dquo[0]),
    .den_o  (dden[0])
  );

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < NW; i++) begin : g_div
    fxa_div_stage #(.NW(NW)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .v_i    (dv[i]),
      .side_i (dside[i]),
      .rem_i  (drem[i]),
      .quo_i  (dquo[i]),
      .den_i  (dden[i]),
      .v_o    (dv[i+1]),
      .side_o (dside[i+1]),
      .rem_o  (drem[i+1]),
      .quo_o  (dquo[i+1]),
      .den_o  (dden[i+1])
    );
  end

  // final remainder and divisor are not needed past the last step
  logic [31:0] res_w;

  fxa_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .v_i      (dv[NW]),
    .side_i   (dside[NW]),
    .quo_i    (dquo[NW]),
    .v_o      (out_valid),
    .result_o (res_w),
    .gt_o     (out_a_greater),
    .lt_o     (out_a_less),
    .eq_o     (out_a_equal),
    .ovf_o    (out_overflow),
    .dbz_o    (out_divide_by_zero)
  );

  assign out_result = res_w;

endmodule

>>> dv/fixed_point_q24_8_alu_tb.sv
// fixed_point_q24_8_alu_tb: self-checking testbench for the q24.8 fixed-point alu
// depends on fxa_pkg and fixed_point_q24_8_alu; predicts each result in 64-bit math
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;
  import fxa_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY = FRAC_BITS + 36;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint R_MAX = 64'sd2147483647;
  localparam longint R_MIN = -64'sd2147483648;

  typedef struct {
    logic [3:0]  func;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct {
    logic [31:0] result;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dbz;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_func = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result;
  logic out_a_greater, out_a_less, out_a_equal, out_overflow, out_divide_by_zero;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit quiet_tail = 0;   // no idling on either side near the end
  int hold_off = 0;     // long receiver stall, counted down by its own process
  int idle_burst = 0;   // remaining idle cycles of the sender

  always #4 clk = ~clk;

  fixed_point_q24_8_alu #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  // round n / d to nearest, ties away from zero, d > 0; unsigned so 2|n| cannot wrap
  function automatic longint round_div(longint n, longint d);
    longint unsigned mag, q, ud;
    mag = (n < 0) ? longint'(-n) : n;
    ud = d;
    q = (mag + mag + ud) / (ud + ud);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic alu_res_t alu_predict(alu_req_t rq);
    alu_res_t rs;
    longint a, b, r, n;
    logic ovf, dbz;
    a = longint'($signed(rq.a));
    b = longint'($signed(rq.b));
    r = 0;
    dbz = 0;
    case (rq.func)
      FN_ADD:  r = a + b;
      FN_SUB:  r = a - b;
      FN_MUL:  r = round_div(a * b, 64'sd1 <<< FRAC_BITS);
      FN_DIV: begin
        if (b == 0) dbz = 1;
        else begin
          n = a <<< FRAC_BITS;
          if (b < 0) n = -n;
          r = round_div(n, (b < 0) ? -b : b);
        end
      end
      FN_MIN:  r = (a < b) ? a : b;
      FN_MAX:  r = (a > b) ? a : b;
      FN_INC:  r = a + 1;
      FN_DEC:  r = a - 1;
      FN_ITOF: r = a <<< FRAC_BITS;
      FN_FTOI: r = a >>> FRAC_BITS;   // arithmetic shift floors, never overflows
      default: r = 0;
    endcase
    // saturate anything outside the signed 32-bit range
    ovf = 0;
    if (r > R_MAX) begin
      r = R_MAX;
      ovf = 1;
    end else if (r < R_MIN) begin
      r = R_MIN;
      ovf = 1;
    end
    rs.result = r[31:0];
    rs.gt = a > b;
    rs.lt = a < b;
    rs.eq = a == b;
    rs.ovf = ovf;
    rs.dbz = dbz;
    return rs;
  endfunction

  function automatic logic [31:0] rand_operand();
    // mostly mid-size values so mul/div stay in range, plus wide and corner values
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 3) == 0 ? 32'h7fff_ffff :
                      ($urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h0);
      3:       return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
      4, 5:    return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      default: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom())};
    endcase
  endfunction

  task automatic push_req(logic [3:0] f, logic [31:0] a, logic [31:0] b);
    alu_req_t rq;
    rq.func = f;
    rq.a = a;
    rq.b = b;
    pending_reqs.push_back(rq);
  endtask

  // driver: offers the head of the pending queue, holds it while stalled
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(alu_predict('{in_func, in_operand_a, in_operand_b}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 &&
            (quiet_tail || (idle_burst == 0 && $urandom_range(0, 5) != 0))) begin
          alu_req_t rq;
          rq = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_func <= rq.func;
          in_operand_a <= rq.a;
          in_operand_b <= rq.b;
        end else begin
          in_valid <= 1'b0;
          // start a random idle burst, or count the current one down
          if (idle_burst > 0) idle_burst <= idle_burst - 1;
          else if (pending_reqs.size() > 0 && !quiet_tail)
            idle_burst <= $urandom_range(0, 2);
        end
      end
    end
  end

  // receiver stall: long hold-off when requested, else short random bursts
  int stall_burst = 0;
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      stall_burst <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", out_result);
      end else begin
        alu_res_t e;
        e = expected_results.pop_front();
        if (e.result !== out_result || e.gt !== out_a_greater || e.lt !== out_a_less ||
            e.eq !== out_a_equal || e.ovf !== out_overflow ||
            e.dbz !== out_divide_by_zero) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("exp r=%h gt%b lt%b eq%b ov%b dz%b  got r=%h gt%b lt%b eq%b ov%b dz%b",
                     e.result, e.gt, e.lt, e.eq, e.ovf, e.dbz, out_result, out_a_greater,
                     out_a_less, out_a_equal, out_overflow, out_divide_by_zero);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_point_q24_8_alu: mismatch");
      $finish;
    end
  end

  initial begin
    // directed: every func on corners, rounding ties, divide by zero, unused codes
    push_req(FN_ADD, 32'h7fff_ffff, 32'h0000_0001);
    push_req(FN_ADD, 32'h8000_0000, 32'h8000_0000);
    push_req(FN_SUB, 32'h8000_0000, 32'h0000_0001);
    push_req(FN_SUB, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(FN_MUL, 32'h0000_0180, 32'h0000_0001);
    push_req(FN_MUL, 32'hffff_fe80, 32'h0000_0001);
    push_req(FN_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    push_req(FN_MUL, 32'h8000_0000, 32'h7fff_ffff);
    push_req(FN_MUL, 32'h8000_0000, 32'h8000_0000);
    push_req(FN_DIV, 32'h0000_0300, 32'h0000_0000);
    push_req(FN_DIV, 32'h8000_0000, 32'h0000_0001);
    push_req(FN_DIV, 32'h8000_0000, 32'hffff_ffff);
    push_req(FN_DIV, 32'h0000_0001, 32'h0000_0200);
    push_req(FN_DIV, 32'hffff_ffff, 32'h0000_0200);
    push_req(FN_MIN, 32'h0000_0005, 32'h0000_0005);
    push_req(FN_MAX, 32'h8000_0000, 32'h7fff_ffff);
    push_req(FN_MIN, 32'h8000_0000, 32'h7fff_ffff);
    push_req(FN_INC, 32'h7fff_ffff, 32'h0);
    push_req(FN_DEC, 32'h8000_0000, 32'h0);
    push_req(FN_ITOF, 32'h0080_0000, 32'h0);
    push_req(FN_ITOF, 32'hff7f_ffff, 32'h0);
    push_req(FN_FTOI, 32'hffff_ff01, 32'h0);
    push_req(FN_FTOI, 32'h8000_0000, 32'h7fff_ffff);
    push_req(4'd10, 32'h1234_5678, 32'h1234_5678);
    push_req(4'd15, 32'hffff_ffff, 32'h0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // random part, with a long receiver hold-off partway through
    for (int i = 0; i < 1350; i++) begin
      logic [31:0] a, b;
      a = rand_operand();
      b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
      push_req($urandom_range(0, 20) == 0 ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9)), a, b);
      if (i == 400) begin
        while (pending_reqs.size() > 0) @(posedge clk);
        hold_off <= 200;
      end
      if (i == 1100) begin
        while (pending_reqs.size() > 0) @(posedge clk);
        quiet_tail <= 1'b1;
      end
    end

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("fixed_point_q24_8_alu: match");
    end else begin
      $display("fixed_point_q24_8_alu: mismatch");
    end
    $finish;
  end

endmodule
